FILE: rtl/cocktail_shaker_sorter_top_defines.svh
// ----------------------------------------------------------------------------
// cocktail shaker sorter assertion macros
// shared property forms for the sorter rtl, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef COCKTAIL_SHAKER_SORTER_TOP_DEFINES_SVH
`define COCKTAIL_SHAKER_SORTER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked on every rising clk edge outside reset
`define CSS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorter assertion failed");
// next-cycle implication
`define CSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorter assertion failed");
`else
`define CSS_ASSERT_NOW(lbl, ante, cons)
`define CSS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/css_pkg.sv
// ----------------------------------------------------------------------------
// css_pkg
// sizes and sequencer state codes of the cocktail shaker sorter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package css_pkg;

    // capacity of the element store
    localparam int MAX_ITEMS = 32;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int DATA_W    = 32;

    // sequencer states, one-hot
    typedef enum logic [10:0] {
        ST_LOAD      = 11'b000_0000_0001,
        ST_FWD_FETCH = 11'b000_0000_0010,
        ST_FWD_CARRY = 11'b000_0000_0100,
        ST_FWD_CMP   = 11'b000_0000_1000,
        ST_FWD_END   = 11'b000_0001_0000,
        ST_BWD_FETCH = 11'b000_0010_0000,
        ST_BWD_CARRY = 11'b000_0100_0000,
        ST_BWD_CMP   = 11'b000_1000_0000,
        ST_BWD_END   = 11'b001_0000_0000,
        ST_EMIT_RD   = 11'b010_0000_0000,
        ST_EMIT_WR   = 11'b100_0000_0000
    } css_state_t;

endpackage

`default_nettype wire

FILE: rtl/cocktail_shaker_sorter_top.sv
// ----------------------------------------------------------------------------
// cocktail_shaker_sorter_top
// loads signed values, sorts them ascending with shaker passes, emits in order
// ----------------------------------------------------------------------------
// Values are loaded one per cycle into a 32-entry store until a transfer
// marked last_item; values beyond capacity are dropped and every result of
// that set shows overflowed. The block then stops taking input while the
// compare logic walks the store in forward and backward passes over [lo,hi],
// one compare-and-write per cycle on the single write port of the store,
// and stops early after a forward pass with no swap. Each result is emitted
// by a store read, then a load of the output register, held while out_stall
// blocks a waiting result; after the final one the block takes the next set,
// even while the final result still waits in the output register. Equal
// values keep their order.
`timescale 1ns / 1ps
`default_nettype none

`include "cocktail_shaker_sorter_top_defines.svh"

module cocktail_shaker_sorter_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic signed [css_pkg::DATA_W-1:0] value,
    input  wire logic                             last_item,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic signed [css_pkg::DATA_W-1:0]     sorted_value,
    output logic                                  last_result,
    output logic                                  overflowed
);

    import css_pkg::*;

    // element store and its registered read
    logic signed [DATA_W-1:0] mem [MAX_ITEMS];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic                     rd_en;
    logic [IDX_W-1:0]         rd_addr;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic signed [DATA_W-1:0] wr_data;

    // sequencer registers
    css_state_t               state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     ovf_reg, ovf_next;
    logic [IDX_W-1:0]         lo_reg, lo_next;
    logic [IDX_W-1:0]         hi_reg, hi_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [IDX_W-1:0]         k_reg, k_next;
    logic signed [DATA_W-1:0] carry_reg, carry_next;
    logic                     swapped_reg, swapped_next;

    // output register
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_value_reg;
    logic                     out_last_reg;
    logic                     out_ovf_reg;
    logic                     out_load;

    logic                     in_xfer;
    logic [CNT_W-1:0]         load_count;
    logic                     fwd_swap;
    logic                     bwd_swap;
    logic                     emit_last;

    assign in_stall     = (state_reg != ST_LOAD);
    assign in_xfer      = in_valid && !in_stall;
    assign out_valid    = out_valid_reg;
    assign sorted_value = out_value_reg;
    assign last_result  = out_last_reg;
    assign overflowed   = out_ovf_reg;

    // compare logic, a separate comparison for each pass direction
    assign fwd_swap  = (carry_reg > rd_data_reg);
    assign bwd_swap  = (rd_data_reg > carry_reg);
    assign emit_last = (CNT_W'(k_reg) + CNT_W'(1)) == count_reg;

    // store count after the current load transfer
    assign load_count = (count_reg < CNT_W'(MAX_ITEMS)) ? count_reg + CNT_W'(1) : count_reg;

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        carry_next     = carry_reg;
        swapped_next   = swapped_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = carry_reg;
        out_load       = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                k_next = '0;
                if (in_xfer)
                begin
                    if (count_reg < CNT_W'(MAX_ITEMS))
                    begin
                        wr_en   = 1'b1;
                        wr_addr = count_reg[IDX_W-1:0];
                        wr_data = value;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    count_next = load_count;
                    if (last_item)
                    begin
                        lo_next = '0;
                        hi_next = IDX_W'(load_count - CNT_W'(1));
                        if (load_count < CNT_W'(2))
                            state_next = ST_EMIT_RD;
                        else
                            state_next = ST_FWD_FETCH;
                    end
                end
            end
            ST_FWD_FETCH:
            begin
                rd_en      = 1'b1;
                rd_addr    = lo_reg;
                idx_next   = lo_reg;
                state_next = ST_FWD_CARRY;
            end
            ST_FWD_CARRY:
            begin
                carry_next   = rd_data_reg;
                swapped_next = 1'b0;
                rd_en        = 1'b1;
                rd_addr      = idx_reg + IDX_W'(1);
                state_next   = ST_FWD_CMP;
            end
            ST_FWD_CMP:
            begin
                // larger value travels up in the carry register
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = fwd_swap ? rd_data_reg : carry_reg;
                if (!fwd_swap)
                    carry_next = rd_data_reg;
                if (fwd_swap)
                    swapped_next = 1'b1;
                idx_next = idx_reg + IDX_W'(1);
                if ((idx_reg + IDX_W'(1)) == hi_reg)
                begin
                    state_next = ST_FWD_END;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = idx_reg + IDX_W'(2);
                end
            end
            ST_FWD_END:
            begin
                wr_en   = 1'b1;
                wr_addr = hi_reg;
                wr_data = carry_reg;
                hi_next = hi_reg - IDX_W'(1);
                if (!swapped_reg)
                    state_next = ST_EMIT_RD;
                else if ((hi_reg - IDX_W'(1)) > lo_reg)
                    state_next = ST_BWD_FETCH;
                else
                    state_next = ST_EMIT_RD;
            end
            ST_BWD_FETCH:
            begin
                rd_en      = 1'b1;
                rd_addr    = hi_reg;
                idx_next   = hi_reg;
                state_next = ST_BWD_CARRY;
            end
            ST_BWD_CARRY:
            begin
                carry_next = rd_data_reg;
                rd_en      = 1'b1;
                rd_addr    = idx_reg - IDX_W'(1);
                state_next = ST_BWD_CMP;
            end
            ST_BWD_CMP:
            begin
                // smaller value travels down in the carry register
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = bwd_swap ? rd_data_reg : carry_reg;
                if (!bwd_swap)
                    carry_next = rd_data_reg;
                idx_next = idx_reg - IDX_W'(1);
                if ((idx_reg - IDX_W'(1)) == lo_reg)
                begin
                    state_next = ST_BWD_END;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = idx_reg - IDX_W'(2);
                end
            end
            ST_BWD_END:
            begin
                wr_en   = 1'b1;
                wr_addr = lo_reg;
                wr_data = carry_reg;
                lo_next = lo_reg + IDX_W'(1);
                if ((lo_reg + IDX_W'(1)) < hi_reg)
                    state_next = ST_FWD_FETCH;
                else
                    state_next = ST_EMIT_RD;
            end
            ST_EMIT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = k_reg;
                state_next = ST_EMIT_WR;
            end
            ST_EMIT_WR:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load = 1'b1;
                    k_next   = k_reg + IDX_W'(1);
                    if (emit_last)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // output handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        idx_reg     <= idx_next;
        k_reg       <= k_next;
        carry_reg   <= carry_next;
        swapped_reg <= swapped_next;
        if (out_load)
        begin
            out_value_reg <= rd_data_reg;
            out_last_reg  <= emit_last;
            out_ovf_reg   <= ovf_reg;
        end
    end

    // store write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // checks on the sequencer
    `CSS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_ITEMS))
    `CSS_ASSERT_NOW(a_fwd_in_range, state_reg == ST_FWD_CMP, idx_reg < hi_reg)
    `CSS_ASSERT_NOW(a_bwd_in_range, state_reg == ST_BWD_CMP, idx_reg > lo_reg)
    `CSS_ASSERT_NOW(a_out_from_emit, $rose(out_valid_reg), $past(state_reg == ST_EMIT_WR))
    `CSS_ASSERT_NEXT(a_last_frees_input, out_load && emit_last, state_reg == ST_LOAD)

endmodule

`default_nettype wire
